/* design/puqat_pkg.sv */
package puqat_pkg;

  localparam int unsigned USERS_DEFAULT   = 1024;
  localparam logic [31:0] KEEPALIVE_RESET = 32'd60;
  localparam logic [31:0] LIFETIME_RESET  = 32'd600;
  localparam logic [5:0]  HDR_WORD_BYTES  = 6'd4;
  localparam logic [47:0] BYTES_MAX       = {48{1'b1}};

  // Register indexes, taken from the word address.
  localparam logic REG_KEEPALIVE = 1'b0;
  localparam logic REG_LIFETIME  = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_UP     = 3'd1,
    OP_DOWN   = 3'd2,
    OP_SCAN   = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    OC_PASS    = 3'd0,
    OC_DROPPED = 3'd1,
    OC_QUOTA   = 3'd2,
    OC_EXPIRED = 3'd3,
    OC_NONE    = 3'd4,
    OC_EMPTY   = 3'd5,
    OC_TAKEN   = 3'd6
  } outcome_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_ACCT = 2'd1,
    MODE_BAD  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SCAN,
    ST_HIT
  } state_e;

  typedef struct packed {
    logic [31:0] keepalive_limit;
    logic [31:0] lifetime_limit;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] start_time;
    logic [31:0] last_seen;
    logic [47:0] up_bytes;
    logic [47:0] down_bytes;
    logic [31:0] up_packets;
    logic [31:0] down_packets;
    logic [31:0] up_dropped;
    logic [31:0] down_dropped;
    logic [3:0]  mode_and_policy;
    logic [31:0] time_allowance;
    logic [47:0] flow_allowance;
  } entry_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? BYTES_MAX : s[47:0];
  endfunction

endpackage

/* design/puqat_if.sv */
interface puqat_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [9:0]  slot;
  logic [31:0] now_seconds;
  logic        is_ipv4;
  logic [15:0] ip_total_length;
  logic [3:0]  ip_header_words;
  logic [1:0]  account_mode;
  logic        limit_by_time;
  logic        limit_by_flow;
  logic [31:0] time_quota;
  logic [47:0] flow_quota;

  modport source (output valid, opcode, slot, now_seconds, is_ipv4, ip_total_length,
                  ip_header_words, account_mode, limit_by_time, limit_by_flow,
                  time_quota, flow_quota, input ready);
  modport sink (input valid, opcode, slot, now_seconds, is_ipv4, ip_total_length,
                ip_header_words, account_mode, limit_by_time, limit_by_flow,
                time_quota, flow_quota, output ready);
endinterface

interface puqat_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic [9:0]  slot_out;
  logic [47:0] byte_total;

  modport source (output valid, outcome, slot_out, byte_total, input ready);
  modport sink (input valid, outcome, slot_out, byte_total, output ready);
endinterface

/* design/per_user_quota_accounting_table.sv */
// Channel   Direction  Beat
// in_i      sink       opcode, slot, time, packet lengths and quota settings of one item
// out_o     source     outcome, slot_out and byte_total of one result
// APB       slave      keepalive_limit at byte 0, lifetime_limit at byte 4
//
// An add, remove or packet that needs no update reads its slot on accept and
// gives its result from the read state; a counted packet goes on to the exec
// state, which writes the updated slot back to the table memory. A scan reads one
// slot a cycle and stops at the first expired slot, freeing it, or after the last.
// After reset a clearing pass writes every slot in turn and marks it free,
// during which no item is accepted; register writes are taken as ever.
// A new item is accepted only when the output register is empty or is being
// emptied in the same cycle, so a stalled result holds off the input.
module per_user_quota_accounting_table
  import puqat_pkg::*;
#(
  parameter int unsigned USERS = USERS_DEFAULT,
  localparam int unsigned IW = $clog2(USERS)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  puqat_in_if.sink    in_i,
  puqat_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t          cfg;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_rdata;

  puqat_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The whole slot lives in one memory word, valid bit included.
  puqat_mem #(.USERS(USERS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  puqat_ctrl #(.USERS(USERS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // An accepted item never finds the output register still full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !out_o.valid)
    else $error("item accepted over a pending result");

  // Write-back and a fresh read never share a cycle, so no forwarding is needed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && in_i.valid && in_i.ready))
    else $error("table written while an item is accepted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (17'(mem_waddr) < 17'(USERS)))
    else $error("table write beyond the last slot");

endmodule

/* design/puqat_cfg.sv */
module puqat_cfg
  import puqat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_KEEPALIVE: cfg_d.keepalive_limit = pwdata;
        REG_LIFETIME:  cfg_d.lifetime_limit  = pwdata;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keepalive_limit <= KEEPALIVE_RESET;
      cfg_q.lifetime_limit  <= LIFETIME_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_KEEPALIVE: prdata = cfg_q.keepalive_limit;
      REG_LIFETIME:  prdata = cfg_q.lifetime_limit;
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule

/* design/puqat_mem.sv */
module puqat_mem
  import puqat_pkg::*;
#(
  parameter int unsigned USERS = USERS_DEFAULT,
  localparam int unsigned IW = $clog2(USERS)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [IW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [USERS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/puqat_ctrl.sv */
module puqat_ctrl
  import puqat_pkg::*;
#(
  parameter int unsigned USERS = USERS_DEFAULT,
  localparam int unsigned IW = $clog2(USERS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  puqat_in_if.sink      in_i,
  puqat_out_if.source   out_o,
  output logic          mem_we_o,
  output logic [IW-1:0] mem_waddr_o,
  output entry_t        mem_wdata_o,
  output logic          mem_re_o,
  output logic [IW-1:0] mem_raddr_o,
  input  entry_t        mem_rdata_i
);

  localparam logic [IW-1:0] LAST = IW'(USERS - 1);

  state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;

  // Item held while it is worked on.
  logic [2:0]  op_q;
  logic [9:0]  slot_q;
  logic        here_q;
  logic [31:0] now_q;
  logic        ipv4_q;
  logic [15:0] pay_q;
  logic [3:0]  pol_q;
  logic [31:0] tq_q;
  logic [47:0] fq_q;

  entry_t      ent_q, ent_d;
  logic [47:0] up_new_q, up_new_d, dn_new_q, dn_new_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  outcome_q, outcome_d;
  logic [9:0]  slot_out_q, slot_out_d;
  logic [47:0] total_q, total_d;

  logic [16:0] slot_wide;
  logic [16:0] idx_wide;
  logic        accept;
  logic [5:0]  hdr_bytes;
  logic [15:0] pay;
  logic [47:0] exec_total;
  logic [31:0] elapsed;
  logic        by_time, by_flow;
  logic        scan_hit;

  assign slot_wide = {7'b0, in_i.slot};
  assign idx_wide  = 17'(idx_q);
  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept = in_i.valid && in_i.ready;

  assign hdr_bytes = {2'b00, in_i.ip_header_words} * HDR_WORD_BYTES;
  assign pay = (in_i.ip_total_length > {10'b0, hdr_bytes})
             ? in_i.ip_total_length - {10'b0, hdr_bytes} : '0;

  assign exec_total = sat_add48(up_new_q, dn_new_q);
  assign elapsed = now_q - ent_q.start_time;
  assign by_time = ent_q.mode_and_policy[2] && (elapsed >= ent_q.time_allowance);
  assign by_flow = ent_q.mode_and_policy[3] && (exec_total >= ent_q.flow_allowance);
  assign scan_hit = mem_rdata_i.valid &&
                    (((now_q - mem_rdata_i.last_seen) >= cfg_i.keepalive_limit) ||
                     ((now_q - mem_rdata_i.start_time) >= cfg_i.lifetime_limit));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    ent_d       = ent_q;
    up_new_d    = up_new_q;
    dn_new_d    = dn_new_q;
    out_valid_d = out_valid_q && !out_o.ready;
    outcome_d   = outcome_q;
    slot_out_d  = slot_out_q;
    total_d     = total_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        idx_d       = idx_q + 1'b1;
        if (idx_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mem_re_o = 1'b1;
          if (in_i.opcode == OP_SCAN) begin
            mem_raddr_o = '0;
            idx_d       = '0;
            state_d     = ST_SCAN;
          end else begin
            mem_raddr_o = slot_wide[IW-1:0];
            state_d     = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        slot_out_d  = slot_q;
        total_d     = '0;
        mem_waddr_o = 17'({7'b0, slot_q}) < 17'(USERS) ? IW'({7'b0, slot_q}) : '0;
        case (op_q)
          OP_ADD: begin
            if (!here_q || mem_rdata_i.valid) begin
              outcome_d = OC_TAKEN;
            end else begin
              outcome_d = OC_PASS;
              mem_we_o  = 1'b1;
              mem_wdata_o.valid           = 1'b1;
              mem_wdata_o.start_time      = now_q;
              mem_wdata_o.last_seen       = now_q;
              mem_wdata_o.mode_and_policy = pol_q;
              mem_wdata_o.time_allowance  = tq_q;
              mem_wdata_o.flow_allowance  = fq_q;
            end
          end
          OP_UP, OP_DOWN: begin
            if (!here_q || !mem_rdata_i.valid) begin
              outcome_d = OC_EMPTY;
            end else if (op_q == OP_UP && !ipv4_q) begin
              outcome_d = OC_PASS;
              total_d   = sat_add48(mem_rdata_i.up_bytes, mem_rdata_i.down_bytes);
            end else begin
              out_valid_d = out_valid_q && !out_o.ready;
              ent_d       = mem_rdata_i;
              up_new_d    = mem_rdata_i.up_bytes;
              dn_new_d    = mem_rdata_i.down_bytes;
              if (op_q == OP_UP) begin
                up_new_d = sat_add48(mem_rdata_i.up_bytes, {32'b0, pay_q});
              end else begin
                dn_new_d = sat_add48(mem_rdata_i.down_bytes, {32'b0, pay_q});
              end
              state_d = ST_EXEC;
            end
          end
          OP_REMOVE: begin
            if (!here_q || !mem_rdata_i.valid) begin
              outcome_d = OC_EMPTY;
            end else begin
              outcome_d   = OC_PASS;
              mem_we_o    = 1'b1;
              mem_wdata_o = mem_rdata_i;
              mem_wdata_o.valid = 1'b0;
            end
          end
          default: outcome_d = OC_PASS;
        endcase
      end
      ST_EXEC: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        slot_out_d  = slot_q;
        total_d     = exec_total;
        mem_we_o    = 1'b1;
        mem_waddr_o = IW'({7'b0, slot_q});
        mem_wdata_o = ent_q;
        mem_wdata_o.up_bytes   = up_new_q;
        mem_wdata_o.down_bytes = dn_new_q;
        mem_wdata_o.last_seen  = now_q;
        if (op_q == OP_UP) begin
          mem_wdata_o.up_packets = ent_q.up_packets + 32'd1;
        end else begin
          mem_wdata_o.down_packets = ent_q.down_packets + 32'd1;
        end
        case (ent_q.mode_and_policy[1:0])
          MODE_ACCT: begin
            if (by_time || by_flow) begin
              outcome_d = OC_QUOTA;
              mem_wdata_o.valid = 1'b0;
            end else begin
              outcome_d = OC_PASS;
            end
          end
          MODE_NONE: outcome_d = OC_PASS;
          default: begin
            outcome_d = OC_DROPPED;
            if (op_q == OP_UP) begin
              mem_wdata_o.up_dropped = ent_q.up_dropped + 32'd1;
            end else begin
              mem_wdata_o.down_dropped = ent_q.down_dropped + 32'd1;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (scan_hit) begin
          ent_d   = mem_rdata_i;
          state_d = ST_HIT;
        end else if (idx_q == LAST) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          outcome_d   = OC_NONE;
          slot_out_d  = '0;
          total_d     = '0;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + 1'b1;
          idx_d       = idx_q + 1'b1;
        end
      end
      ST_HIT: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        outcome_d   = OC_EXPIRED;
        slot_out_d  = idx_wide[9:0];
        total_d     = sat_add48(ent_q.up_bytes, ent_q.down_bytes);
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = ent_q;
        mem_wdata_o.valid = 1'b0;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    up_new_q   <= up_new_d;
    dn_new_q   <= dn_new_d;
    outcome_q  <= outcome_d;
    slot_out_q <= slot_out_d;
    total_q    <= total_d;
    if (accept) begin
      op_q   <= in_i.opcode;
      slot_q <= in_i.slot;
      here_q <= slot_wide < 17'(USERS);
      now_q  <= in_i.now_seconds;
      ipv4_q <= in_i.is_ipv4;
      pay_q  <= pay;
      pol_q  <= {in_i.limit_by_flow, in_i.limit_by_time, in_i.account_mode};
      tq_q   <= in_i.time_quota;
      fq_q   <= in_i.flow_quota;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.outcome    = outcome_q;
  assign out_o.slot_out   = slot_out_q;
  assign out_o.byte_total = total_q;

endmodule
